### hw/rtl/rrcs_pkg.sv
// ----------------------------------------------------------------------------
// rrcs_pkg: shared types and constants of the round-robin CPU scheduler
// Slot count, field widths, result kinds, ready-ring entry and result bundle.
// ----------------------------------------------------------------------------
package rrcs_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int CNT_BITS  = SLOT_BITS + 1;
  localparam int ID_BITS   = 16;

  localparam int PID_W   = 16;
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_BITS-1:0] SLOTS_CNT = CNT_BITS'(SLOTS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_RUN    = 3'd0,
    KIND_IDLE   = 3'd1,
    KIND_START  = 3'd2,
    KIND_FINISH = 3'd3,
    KIND_REJECT = 3'd4
  } kind_t;

  // result positions inside one bundle, in delivery order
  localparam int POS_START  = 0;
  localparam int POS_IDLE   = 1;
  localparam int POS_RUN    = 2;
  localparam int POS_FINISH = 3;
  localparam int NPOS       = 4;

  typedef struct packed {
    logic [ID_BITS-1:0] ident;
    logic [DATA_W-1:0]  remaining;
    logic               started;
  } proc_t;

  // all results caused by one input item
  typedef struct packed {
    logic [NPOS-1:0]   mask;
    kind_t             first_kind;   // start or reject
    logic [ID_BITS-1:0] ident;
    logic [DATA_W-1:0] time_first;   // start / reject time
    logic [DATA_W-1:0] time_finish;
  } bundle_t;

  function automatic logic [ID_BITS-1:0] mask_id(input logic [PID_W-1:0] x);
    logic [ID_BITS+PID_W-1:0] w;
    w = {{ID_BITS{1'b0}}, x};
    return w[ID_BITS-1:0];
  endfunction

  function automatic logic [PID_W-1:0] out_id(input logic [ID_BITS-1:0] x);
    logic [ID_BITS+PID_W-1:0] w;
    w = {{PID_W{1'b0}}, x};
    return w[PID_W-1:0];
  endfunction

endpackage

### hw/rtl/rrcs_core.sv
// ----------------------------------------------------------------------------
// rrcs_core: scheduler state and combinational item processing
// Holds ready ring, running process and counters; at most one bundle per item.
// ----------------------------------------------------------------------------
module rrcs_core
  import rrcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_accept,
  input  logic                 in_tick,
  input  logic [PID_W-1:0]     in_pid,
  input  logic [DATA_W-1:0]    in_burst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_val,
  output logic                 bundle_valid,
  output bundle_t              bundle
);

  logic [DATA_W-1:0]    quantum, seq_limit;
  proc_t                ring [SLOTS];
  logic [SLOT_BITS-1:0] ring_head, ring_head_next;
  logic [CNT_BITS-1:0]  ring_count, ring_count_next;
  logic [CNT_BITS-1:0]  slots_used, slots_used_next;
  logic                 cpu_busy, cpu_busy_next;
  logic [ID_BITS-1:0]   cur_ident, cur_ident_next;
  logic [DATA_W-1:0]    cur_rem, cur_rem_next;
  logic [DATA_W-1:0]    slice_left, slice_left_next;
  logic [DATA_W-1:0]    now_count, now_count_next;
  logic                 was_idle, was_idle_next;
  logic [DATA_W-1:0]    entries_sent, entries_sent_next;

  logic                 ring_we;
  logic [SLOT_BITS-1:0] ring_waddr;
  proc_t                ring_wdata;
  logic [DATA_W-1:0]    eff_q;

  assign eff_q = (quantum == '0) ? DATA_W'(1) : quantum;

  function automatic logic [SLOT_BITS-1:0] tail_of(input logic [SLOT_BITS-1:0] h,
                                                   input logic [CNT_BITS-1:0] c);
    logic [CNT_BITS-1:0] s;
    s = CNT_BITS'(h) + c;
    if (s >= SLOTS_CNT) s = s - SLOTS_CNT;
    return s[SLOT_BITS-1:0];
  endfunction

  always_comb begin
    proc_t                run;
    logic                 active;
    logic [SLOT_BITS-1:0] h;
    logic [CNT_BITS-1:0]  c;
    logic [DATA_W-1:0]    sl;
    logic                 wi;
    logic [DATA_W-1:0]    sent;

    run  = '{ident: cur_ident, remaining: cur_rem, started: 1'b1};
    active = cpu_busy;
    h    = ring_head;
    c    = ring_count;
    sl   = slice_left;
    wi   = was_idle;
    sent = entries_sent;

    ring_we    = 1'b0;
    ring_waddr = tail_of(ring_head, ring_count);
    ring_wdata = '{ident: mask_id(in_pid),
                   remaining: (in_burst == '0) ? DATA_W'(1) : in_burst,
                   started: 1'b0};

    slots_used_next = slots_used;
    now_count_next  = now_count;

    bundle             = '0;
    bundle.first_kind  = KIND_START;
    bundle.time_first  = now_count;
    bundle.time_finish = now_count + DATA_W'(1);

    if (in_accept && !in_tick) begin
      bundle.ident = mask_id(in_pid);
      if (slots_used >= SLOTS_CNT) begin
        bundle.mask[POS_START] = 1'b1;
        bundle.first_kind      = KIND_REJECT;
      end else begin
        slots_used_next = slots_used + CNT_BITS'(1);
        if (c < SLOTS_CNT) begin
          ring_we = 1'b1;
          c = c + CNT_BITS'(1);
        end
      end
    end else if (in_accept) begin
      // dispatch from the ring head when the CPU is free
      if (!cpu_busy && c != '0) begin
        run = ring[h];
        h = (h == SLOT_BITS'(SLOTS - 1)) ? '0 : h + SLOT_BITS'(1);
        c = c - CNT_BITS'(1);
        active = 1'b1;
        sl = eff_q;
        if (!run.started) bundle.mask[POS_START] = 1'b1;
        run.started = 1'b1;
        if (wi) begin
          if (sent < seq_limit) begin
            bundle.mask[POS_IDLE] = 1'b1;
            sent = sent + DATA_W'(1);
          end
          wi = 1'b0;
        end
      end
      if (active) begin
        run.remaining = run.remaining - DATA_W'(1);
        sl = sl - DATA_W'(1);
      end else begin
        wi = 1'b1;
      end
      now_count_next = now_count + DATA_W'(1);
      if (active) begin
        if (run.remaining == '0) begin
          if (sent < seq_limit) begin
            bundle.mask[POS_RUN] = 1'b1;
            sent = sent + DATA_W'(1);
          end
          bundle.mask[POS_FINISH] = 1'b1;
          active = 1'b0;
          sl = eff_q;
        end else if (sl == '0) begin
          // preempt only when someone else waits; otherwise renew the slice
          if (c != '0) begin
            if (sent < seq_limit) begin
              bundle.mask[POS_RUN] = 1'b1;
              sent = sent + DATA_W'(1);
            end
            if (c < SLOTS_CNT) begin
              ring_we    = 1'b1;
              ring_waddr = tail_of(h, c);
              ring_wdata = run;
              c = c + CNT_BITS'(1);
            end
            active = 1'b0;
          end
          sl = eff_q;
        end
      end
      bundle.ident = run.ident;
    end

    ring_head_next    = h;
    ring_count_next   = c;
    cpu_busy_next     = active;
    cur_ident_next    = run.ident;
    cur_rem_next      = run.remaining;
    slice_left_next   = sl;
    was_idle_next     = wi;
    entries_sent_next = sent;
  end

  assign bundle_valid = in_accept && (bundle.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum      <= DATA_W'(1);
      seq_limit    <= '0;
      ring_head    <= '0;
      ring_count   <= '0;
      slots_used   <= '0;
      cpu_busy     <= 1'b0;
      slice_left   <= '0;
      now_count    <= '0;
      was_idle     <= 1'b0;
      entries_sent <= '0;
    end else begin
      if (cfg_we && cfg_idx == CFG_QUANTUM)   quantum   <= cfg_val;
      if (cfg_we && cfg_idx == CFG_SEQ_LIMIT) seq_limit <= cfg_val;
      if (in_accept) begin
        ring_head    <= ring_head_next;
        ring_count   <= ring_count_next;
        slots_used   <= slots_used_next;
        cpu_busy     <= cpu_busy_next;
        slice_left   <= slice_left_next;
        now_count    <= now_count_next;
        was_idle     <= was_idle_next;
        entries_sent <= entries_sent_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_ident <= cur_ident_next;
      cur_rem   <= cur_rem_next;
    end
    if (ring_we) ring[ring_waddr] <= ring_wdata;
  end

  // every queued or running process owns a slot
  a_ring_fits: assert property (@(posedge clk) disable iff (rst)
    (CNT_BITS + 1)'(ring_count) + (CNT_BITS + 1)'(cpu_busy) <= (CNT_BITS + 1)'(slots_used))
    else $error("ring plus running exceeds slots in use");

  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= SLOTS_CNT)
    else $error("slots_used beyond slot count");

  // a running process always has work left
  a_busy_rem: assert property (@(posedge clk) disable iff (rst)
    cpu_busy |-> cur_rem != '0)
    else $error("running process with no remaining time");

  // a finish result always leaves the CPU free
  a_finish_frees: assert property (@(posedge clk) disable iff (rst)
    (bundle_valid && bundle.mask[POS_FINISH]) |=> !cpu_busy || $past(ring_count) != '0)
    else $error("finish without releasing the CPU");

endmodule

### hw/rtl/rrcs_out.sv
// ----------------------------------------------------------------------------
// rrcs_out: result bundle queue and serializer
// Two-entry bundle FIFO; sends the set positions of the head bundle one per beat.
// ----------------------------------------------------------------------------
module rrcs_out
  import rrcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bundle_t           push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output kind_t             out_kind,
  output logic [PID_W-1:0]  out_pid,
  output logic [DATA_W-1:0] out_time,
  output logic              out_last
);

  bundle_t         fifo [2];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      fill;
  logic [NPOS-1:0] done;
  logic [NPOS-1:0] pending, sel, rest;
  bundle_t         head;
  logic            pop;

  assign head      = fifo[rd_ptr];
  assign space     = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign pending   = head.mask & ~done;

  always_comb begin
    sel = '0;
    priority if (pending[POS_START]) sel[POS_START] = 1'b1;
    else if (pending[POS_IDLE])      sel[POS_IDLE]  = 1'b1;
    else if (pending[POS_RUN])       sel[POS_RUN]   = 1'b1;
    else                             sel[POS_FINISH] = 1'b1;
  end

  assign rest     = pending & ~sel;
  assign out_last = (rest == '0);

  always_comb begin
    out_kind = KIND_FINISH;
    out_pid  = out_id(head.ident);
    out_time = head.time_finish;
    priority if (sel[POS_START]) begin
      out_kind = head.first_kind;
      out_time = head.time_first;
    end else if (sel[POS_IDLE]) begin
      out_kind = KIND_IDLE;
      out_pid  = '0;
      out_time = '0;
    end else if (sel[POS_RUN]) begin
      out_kind = KIND_RUN;
      out_time = '0;
    end else begin
      out_kind = KIND_FINISH;
    end
  end

  assign pop = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
      done   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
      if (pop) done <= '0;
      else if (out_valid && out_ready) done <= done | sel;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("bundle pushed into full queue");

  a_head_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("head bundle has nothing left to send");

endmodule

### hw/rtl/round_robin_cpu_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_cpu_scheduler_unit: round-robin scheduler with a time quantum
// Stream in arrive/tick items, stream out run, idle, start, finish, reject.
// ----------------------------------------------------------------------------
// Each input transaction is processed in the cycle it is accepted: an arrive
// (s_tuser = 0) takes a slot and joins the tail of the ready ring, a tick
// (s_tuser = 1) dispatches the ring head if the CPU is free, runs one time
// unit and then reports a finish or preempts when the slice is used up and
// others wait. All results of one item land as one bundle in a two-entry
// queue; the output side sends them one per transaction, start, idle, run,
// finish in that order, with m_tlast on the item's final result. Items
// with no result queue nothing. Input is taken in every cycle while the queue
// has room, so the sustained rate is one item per cycle, or one output
// transaction per result where items cause several (up to four per tick).
// Slots are never reused before reset; an arrival beyond the slot count
// returns one reject result. quantum (index 0) and sequence_limit (index 1)
// are written through the cfg channel, which is always ready; write them
// only while the block is idle.
// ----------------------------------------------------------------------------
module round_robin_cpu_scheduler_unit
  import rrcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,   // [15:0] process_id, [47:16] burst_length
  input  logic [0:0]           s_tuser,   // [0] operation
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,   // [15:0] result_id, [47:16] event_time
  output logic [KIND_W-1:0]    m_tuser,   // [2:0] kind
  output logic                 m_tlast,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  logic              accept;
  logic              space;
  logic              bundle_valid;
  bundle_t           bundle;
  kind_t             out_kind;
  logic [PID_W-1:0]  out_pid;
  logic [DATA_W-1:0] out_time;

  assign s_tready  = space;
  assign accept    = s_tvalid && space;
  assign cfg_ready = 1'b1;

  rrcs_core u_core (
    .clk          (clk),
    .rst          (rst),
    .in_accept    (accept),
    .in_tick      (s_tuser[0]),
    .in_pid       (s_tdata[15:0]),
    .in_burst     (s_tdata[47:16]),
    .cfg_we       (cfg_valid),
    .cfg_idx      (cfg_index),
    .cfg_val      (cfg_data),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  rrcs_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (bundle_valid),
    .push_data (bundle),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (out_kind),
    .out_pid   (out_pid),
    .out_time  (out_time),
    .out_last  (m_tlast)
  );

  assign m_tdata = {out_time, out_pid};
  assign m_tuser = out_kind;

endmodule
